[sv/akso_pkg.sv]
// Package: payload types, constants and fixed-point helpers of the arm observation unit.
`default_nettype none
package akso_pkg;

	typedef struct packed {
		logic signed [15:0] joint_angle_0;
		logic signed [15:0] joint_angle_1;
		logic signed [15:0] joint_angle_2;
		logic signed [15:0] joint_angle_3;
		logic signed [15:0] joint_angle_4;
		logic signed [31:0] noise_u0;
		logic signed [31:0] noise_v0;
		logic signed [31:0] noise_u1;
		logic signed [31:0] noise_v1;
	} req_t;

	typedef struct packed {
		logic signed [31:0] obs_u0;
		logic signed [31:0] obs_v0;
		logic signed [31:0] obs_u1;
		logic signed [31:0] obs_v1;
		logic signed [15:0] tip_x;
		logic signed [15:0] tip_y;
		logic signed [15:0] tip_z;
		logic               cam0_degenerate;
		logic               cam1_degenerate;
	} rsp_t;

	// register indexes
	localparam logic [2:0] CAM0_X  = 3'd0;
	localparam logic [2:0] CAM0_Y  = 3'd1;
	localparam logic [2:0] CAM0_Z  = 3'd2;
	localparam logic [2:0] CAM1_X  = 3'd3;
	localparam logic [2:0] CAM1_Y  = 3'd4;
	localparam logic [2:0] CAM1_Z  = 3'd5;
	localparam logic [2:0] NUM_CFG = 3'd6;

	localparam logic signed [31:0] L1_Q16 = 32'sd475136;
	localparam logic signed [31:0] L2_Q16 = 32'sd524288;
	localparam logic signed [31:0] L3_Q16 = 32'sd679936;
	localparam logic signed [31:0] L4_Q16 = 32'sd155648;

	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
	localparam int                 CORDIC_STEPS = 16;
	localparam int                 DIV_STEPS    = 33;

	localparam logic signed [19:0] ATAN_TAB [CORDIC_STEPS] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
		20'sd8, 20'sd4, 20'sd2
	};

	// Q16.16 product, rounded to nearest
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + 64'sd32768;
		return p[47:16];
	endfunction

	// round Q16.16 to Q8.8 and clamp to 16 bits
	function automatic logic signed [15:0] to_q8(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = (33'(v) + 33'sd128) >>> 8;
		if (t > 33'sd32767)
			return 16'sh7fff;
		else if (t < -33'sd32768)
			return 16'sh8000;
		return t[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -35'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

[sv/arm_kinematics_stereo_observation_unit.sv]
// Top level: pipelined forward kinematics of a five-link arm and two camera ratios.
//
// Requests on req_valid/req_data are taken at an edge where req_valid is high and
// req_stall is low; results on rsp_valid/rsp_data are taken where rsp_valid is high
// and rsp_stall is low. Camera positions are written via cfg_we/cfg_index/cfg_data,
// one register per edge; the user must write only when the pipe is empty (unchecked).
//
// One request enters every cycle while req_stall is low: a fold stage, sixteen
// CORDIC stages and a rounding stage give sine and cosine of all five joints, four
// multiply stages and a rounding stage run the kinematic chain, and a setup stage
// plus a 33-stage restoring divider, one quotient bit per stage, form the four
// ratios. A final stage adds noise, saturates and zeroes degenerate cameras' ratios.
//
// Reset clears all stage valid bits and sets the camera registers to zero. While
// the output register holds a result that is stalled, the whole pipe holds and
// req_stall is raised; nothing is dropped or repeated.
`default_nettype none
module arm_kinematics_stereo_observation_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire akso_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output akso_pkg::rsp_t     rsp_data,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);
	import akso_pkg::*;

	localparam int ST_ROUND = CORDIC_STEPS + 2;   // 18
	localparam int ST_TIP   = ST_ROUND + 5;       // 23
	localparam int ST_DIV0  = ST_TIP + 1;         // 24
	localparam int ST_LAST  = ST_DIV0 + DIV_STEPS; // 57
	localparam int LAT      = ST_LAST + 1;        // 58

	logic en;
	logic vld_s [1:LAT];
	logic signed [15:0] cam_q [NUM_CFG];

	// CORDIC
	logic signed [33:0] cx_s [0:CORDIC_STEPS][0:4];
	logic signed [33:0] cy_s [0:CORDIC_STEPS][0:4];
	logic signed [19:0] cz_s [0:CORDIC_STEPS][0:4];
	logic               cf_s [0:CORDIC_STEPS][0:4];
	logic signed [15:0] ang [0:4];
	logic signed [19:0] zin [0:4];
	logic signed [33:0] xr [0:4];
	logic signed [33:0] yr [0:4];

	logic signed [31:0] sn_s18 [0:4];
	logic signed [31:0] cs_s18 [0:4];
	logic signed [31:0] sn_s19 [0:3];
	logic signed [31:0] cs_s19 [0:3];
	logic signed [31:0] s4l4_s19, c4l4l3_s19, c2c3_s19, s2c3_s19;
	logic signed [31:0] sn_s20 [0:1];
	logic signed [31:0] cs_s20 [0:1];
	logic signed [31:0] a_s20, b_s20, q_s20;
	logic signed [31:0] sn0_s21, cs0_s21, p_s21, py_s21, q_s21;
	logic signed [31:0] px_s22, py_s22, pz_s22;

	logic signed [31:0] noise_s [1:ST_LAST][0:3];
	logic signed [15:0] tip_s [ST_TIP:ST_LAST][0:2];
	logic               deg_s [ST_DIV0:ST_LAST][0:1];

	// divider lanes: u0, v0, u1, v1
	logic [32:0] dnum_s [0:DIV_STEPS][0:3];
	logic [16:0] drem_s [0:DIV_STEPS][0:3];
	logic [16:0] dden_s [0:DIV_STEPS][0:3];
	logic        dneg_s [0:DIV_STEPS][0:3];
	logic [17:0] dpart [0:DIV_STEPS-1][0:3];

	logic signed [16:0] doff [0:1][0:2];
	logic [16:0]        dmag [0:1][0:2];

	logic signed [33:0] qs [0:3];
	logic signed [31:0] obs [0:3];

	rsp_t rsp_q;

	assign en        = !vld_s[LAT] || !rsp_stall;
	assign req_stall = !en;
	assign rsp_valid = vld_s[LAT];
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= req_valid;
			for (int k = 2; k <= LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CFG; k++)
				cam_q[k] <= '0;
		end else if (cfg_we && cfg_index < NUM_CFG) begin
			cam_q[cfg_index] <= cfg_data;
		end
	end

	// angle widening into the first CORDIC stage
	always_comb begin
		ang[0] = req_data.joint_angle_0;
		ang[1] = req_data.joint_angle_1;
		ang[2] = req_data.joint_angle_2;
		ang[3] = req_data.joint_angle_3;
		ang[4] = req_data.joint_angle_4;
		for (int j = 0; j < 5; j++)
			zin[j] = {ang[j][15], ang[j], 3'b000};
	end

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			xr[j] = cx_s[CORDIC_STEPS][j] + 34'sd8192;
			yr[j] = cy_s[CORDIC_STEPS][j] + 34'sd8192;
		end
	end

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++)
			for (int l = 0; l < 4; l++)
				dpart[k][l] = {drem_s[k][l], dnum_s[k][l][32]};
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			for (int e = 0; e < 3; e++) begin
				doff[c][e] = 17'(tip_s[ST_TIP][e]) - 17'(cam_q[3*c+e]);
				dmag[c][e] = doff[c][e][16] ? 17'(-doff[c][e]) : 17'(doff[c][e]);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			qs[l] = dneg_s[DIV_STEPS][l] ? -34'({1'b0, dnum_s[DIV_STEPS][l]})
				: 34'({1'b0, dnum_s[DIV_STEPS][l]});
			obs[l] = sat32(35'(qs[l]) + 35'(noise_s[ST_LAST][l]));
			if (deg_s[ST_LAST][l/2])
				obs[l] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// reduce by pi and flip sign outside +-pi/2
			for (int j = 0; j < 5; j++) begin
				cx_s[0][j] <= CORDIC_K;
				cy_s[0][j] <= '0;
				if (zin[j] > HALF_PI_Q16) begin
					cz_s[0][j] <= zin[j] - PI_Q16;
					cf_s[0][j] <= 1'b1;
				end else if (zin[j] < -HALF_PI_Q16) begin
					cz_s[0][j] <= zin[j] + PI_Q16;
					cf_s[0][j] <= 1'b1;
				end else begin
					cz_s[0][j] <= zin[j];
					cf_s[0][j] <= 1'b0;
				end
			end

			for (int i = 0; i < CORDIC_STEPS; i++) begin
				for (int j = 0; j < 5; j++) begin
					cf_s[i+1][j] <= cf_s[i][j];
					if (cz_s[i][j] >= 0) begin
						cx_s[i+1][j] <= cx_s[i][j] - (cy_s[i][j] >>> i);
						cy_s[i+1][j] <= cy_s[i][j] + (cx_s[i][j] >>> i);
						cz_s[i+1][j] <= cz_s[i][j] - ATAN_TAB[i];
					end else begin
						cx_s[i+1][j] <= cx_s[i][j] + (cy_s[i][j] >>> i);
						cy_s[i+1][j] <= cy_s[i][j] - (cx_s[i][j] >>> i);
						cz_s[i+1][j] <= cz_s[i][j] + ATAN_TAB[i];
					end
				end
			end

			for (int j = 0; j < 5; j++) begin
				cs_s18[j] <= cf_s[CORDIC_STEPS][j] ? -32'(xr[j] >>> 14) : 32'(xr[j] >>> 14);
				sn_s18[j] <= cf_s[CORDIC_STEPS][j] ? -32'(yr[j] >>> 14) : 32'(yr[j] >>> 14);
			end

			// kinematic chain
			s4l4_s19   <= mulq(sn_s18[4], L4_Q16);
			c4l4l3_s19 <= mulq(cs_s18[4], L4_Q16) + L3_Q16;
			c2c3_s19   <= mulq(cs_s18[2], cs_s18[3]);
			s2c3_s19   <= mulq(sn_s18[2], cs_s18[3]);
			for (int j = 0; j < 4; j++) begin
				sn_s19[j] <= sn_s18[j];
				cs_s19[j] <= cs_s18[j];
			end

			a_s20 <= mulq(sn_s19[2], c4l4l3_s19) + mulq(c2c3_s19, s4l4_s19);
			b_s20 <= mulq(cs_s19[2], c4l4l3_s19) - mulq(s2c3_s19, s4l4_s19) + L2_Q16;
			q_s20 <= mulq(sn_s19[3], s4l4_s19);
			for (int j = 0; j < 2; j++) begin
				sn_s20[j] <= sn_s19[j];
				cs_s20[j] <= cs_s19[j];
			end

			p_s21   <= mulq(cs_s20[1], a_s20) + mulq(sn_s20[1], b_s20);
			py_s21  <= mulq(cs_s20[1], b_s20) - mulq(sn_s20[1], a_s20) + L1_Q16;
			q_s21   <= q_s20;
			sn0_s21 <= sn_s20[0];
			cs0_s21 <= cs_s20[0];

			px_s22 <= mulq(sn0_s21, p_s21) + mulq(cs0_s21, q_s21);
			pz_s22 <= mulq(cs0_s21, p_s21) - mulq(sn0_s21, q_s21);
			py_s22 <= py_s21;

			tip_s[ST_TIP][0] <= to_q8(px_s22);
			tip_s[ST_TIP][1] <= to_q8(py_s22);
			tip_s[ST_TIP][2] <= to_q8(pz_s22);

			// divider setup: magnitudes and quotient sign
			for (int c = 0; c < 2; c++) begin
				deg_s[ST_DIV0][c] <= (doff[c][1] == '0);
				for (int m = 0; m < 2; m++) begin
					dnum_s[0][2*c+m] <= {dmag[c][2*m], 16'h0000};
					drem_s[0][2*c+m] <= '0;
					dden_s[0][2*c+m] <= dmag[c][1];
					dneg_s[0][2*c+m] <= doff[c][2*m][16] ^ doff[c][1][16];
				end
			end

			for (int k = 0; k < DIV_STEPS; k++) begin
				for (int l = 0; l < 4; l++) begin
					dden_s[k+1][l] <= dden_s[k][l];
					dneg_s[k+1][l] <= dneg_s[k][l];
					if (dpart[k][l] >= {1'b0, dden_s[k][l]}) begin
						drem_s[k+1][l] <= 17'(dpart[k][l] - {1'b0, dden_s[k][l]});
						dnum_s[k+1][l] <= {dnum_s[k][l][31:0], 1'b1};
					end else begin
						drem_s[k+1][l] <= dpart[k][l][16:0];
						dnum_s[k+1][l] <= {dnum_s[k][l][31:0], 1'b0};
					end
				end
			end

			// side lines
			noise_s[1][0] <= req_data.noise_u0;
			noise_s[1][1] <= req_data.noise_v0;
			noise_s[1][2] <= req_data.noise_u1;
			noise_s[1][3] <= req_data.noise_v1;
			for (int k = 2; k <= ST_LAST; k++)
				for (int l = 0; l < 4; l++)
					noise_s[k][l] <= noise_s[k-1][l];
			for (int k = ST_TIP + 1; k <= ST_LAST; k++)
				for (int e = 0; e < 3; e++)
					tip_s[k][e] <= tip_s[k-1][e];
			for (int k = ST_DIV0 + 1; k <= ST_LAST; k++)
				for (int c = 0; c < 2; c++)
					deg_s[k][c] <= deg_s[k-1][c];

			rsp_q.obs_u0          <= obs[0];
			rsp_q.obs_v0          <= obs[1];
			rsp_q.obs_u1          <= obs[2];
			rsp_q.obs_v1          <= obs[3];
			rsp_q.tip_x           <= tip_s[ST_LAST][0];
			rsp_q.tip_y           <= tip_s[ST_LAST][1];
			rsp_q.tip_z           <= tip_s[ST_LAST][2];
			rsp_q.cam0_degenerate <= deg_s[ST_LAST][0];
			rsp_q.cam1_degenerate <= deg_s[ST_LAST][1];
		end
	end

endmodule
`default_nettype wire
